>>> sv/transformed_mesh_bounding_box_assert.svh
// Assertion macros for the mesh bounding box block
`ifndef TRANSFORMED_MESH_BOUNDING_BOX_ASSERT_SVH
`define TRANSFORMED_MESH_BOUNDING_BOX_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TMBB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define TMBB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/tmbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbb_pkg
// Shared types and constants for the mesh bounding box block.
// ----------------------------------------------------------------------------
package tmbb_pkg;
  localparam int CoordW = 24;
  localparam int SizeW  = 23;
  localparam int TrigW  = 16;
  localparam int VertW  = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam int AccW   = 64;   // Q.28 accumulator width
  localparam int MulW   = 41;   // multiplier operand (diff) width

  localparam logic [CfgIdxW-1:0] REG_POS_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POS_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SIZE_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SIN = 3'd5;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [SizeW-1:0]  size_t;
  typedef logic signed [TrigW-1:0]  trig_t;
  typedef logic signed [VertW-1:0]  vert_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    size_t  size_x;
    size_t  size_y;
    trig_t  cos_a;
    trig_t  sin_a;
  } cfg_t;

  typedef struct packed {
    vert_t a_x; vert_t a_y; vert_t b_x; vert_t b_y; vert_t c_x; vert_t c_y;
    logic  last_triangle;
  } tri_t;

  typedef struct packed {
    coord_t box_left;
    coord_t box_top;
    size_t  box_width;
    size_t  box_height;
  } box_t;
endpackage

>>> sv/tmbb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbb_tri_if / tmbb_box_if
// Valid/ready channels for triangles in and boxes out.
// ----------------------------------------------------------------------------
interface tmbb_tri_if;
  logic valid;
  logic ready;
  tmbb_pkg::tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmbb_box_if;
  logic valid;
  logic ready;
  tmbb_pkg::box_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/tmbb_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbb_xform
// Bit-serial transform of one vertex: shift-add products, round, saturate.
// ----------------------------------------------------------------------------
module tmbb_xform (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  tmbb_pkg::cfg_t          cfg,
  input  tmbb_pkg::vert_t         vx,
  input  tmbb_pkg::vert_t         vy,
  output logic                    done,
  output tmbb_pkg::coord_t        ox,
  output tmbb_pkg::coord_t        oy
);
  import tmbb_pkg::*;

  // Phases: P_D multiplies v by size serially (16 bits of v),
  // P_ROT multiplies dx,dy by cos,sin serially (16 bits of trig).
  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_D    = 3'd1;
  localparam logic [2:0] P_ROT  = 3'd2;
  localparam logic [2:0] P_FIN  = 3'd3;

  logic [2:0] ph_r, ph_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [VertW-1:0] vx_sh_r, vx_sh_nxt, vy_sh_r, vy_sh_nxt;
  logic [TrigW-1:0] c_sh_r, c_sh_nxt, s_sh_r, s_sh_nxt;
  logic signed [MulW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [AccW-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  coord_t ox_r, ox_nxt, oy_r, oy_nxt;
  logic done_r, done_nxt;

  logic msb_v;
  logic signed [MulW-1:0] sx_w, sy_w, addx, addy;
  logic signed [AccW-1:0] dxe, dye, tx, ty, rx, ry, bx, by;

  function automatic coord_t rnd_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] b;
    logic signed [AccW-29:0] q;
    begin
      b = v + (AccW'(1) <<< 27);
      q = b[AccW-1:28];
      if (q > (AccW-28)'(8388607)) rnd_sat = 24'sd8388607;
      else if (q < -(AccW-28)'(8388608)) rnd_sat = -24'sd8388608;
      else rnd_sat = q[CoordW-1:0];
    end
  endfunction

  always_comb begin
    sx_w = MulW'(cfg.size_x);
    sy_w = MulW'(cfg.size_y);
    msb_v = (cnt_r == 5'd15);
    // weight of bit k is 2^k, sign bit negative; accumulate shifted size
    addx = vx_sh_r[0] ? (sx_w <<< cnt_r) : '0;
    addy = vy_sh_r[0] ? (sy_w <<< cnt_r) : '0;
    dxe = AccW'(dx_r) <<< cnt_r;
    dye = AccW'(dy_r) <<< cnt_r;
    tx = c_sh_r[0] ? dxe : '0;
    ty = s_sh_r[0] ? dye : '0;
    rx = ax_r; ry = ay_r;
    ph_nxt = ph_r; cnt_nxt = cnt_r;
    vx_sh_nxt = vx_sh_r; vy_sh_nxt = vy_sh_r;
    c_sh_nxt = c_sh_r; s_sh_nxt = s_sh_r;
    dx_nxt = dx_r; dy_nxt = dy_r; ax_nxt = ax_r; ay_nxt = ay_r;
    ox_nxt = ox_r; oy_nxt = oy_r; done_nxt = 1'b0;
    bx = '0; by = '0;
    case (ph_r)
      P_IDLE: begin
        if (start) begin
          ph_nxt = P_D; cnt_nxt = '0;
          vx_sh_nxt = vx; vy_sh_nxt = vy;
          dx_nxt = -(sx_w <<< 13); dy_nxt = -(sy_w <<< 13);
        end
      end
      P_D: begin
        dx_nxt = msb_v ? dx_r - addx : dx_r + addx;
        dy_nxt = msb_v ? dy_r - addy : dy_r + addy;
        vx_sh_nxt = vx_sh_r >> 1; vy_sh_nxt = vy_sh_r >> 1;
        cnt_nxt = cnt_r + 5'd1;
        if (msb_v) begin
          ph_nxt = P_ROT; cnt_nxt = '0;
          c_sh_nxt = cfg.cos_a; s_sh_nxt = cfg.sin_a;
          ax_nxt = (AccW'(sx_w) <<< 27) + (AccW'(cfg.pos_x) <<< 28);
          ay_nxt = (AccW'(sy_w) <<< 27) + (AccW'(cfg.pos_y) <<< 28);
        end
      end
      P_ROT: begin
        // x += dx*c - dy*s ; y += dx*s + dy*c, one trig bit per cycle
        bx = s_sh_r[0] ? dxe : '0;
        by = c_sh_r[0] ? dye : '0;
        if (msb_v) begin
          ax_nxt = ax_r - tx + ty;
          ay_nxt = ay_r - bx - by;
          ph_nxt = P_FIN;
        end else begin
          ax_nxt = ax_r + tx - ty;
          ay_nxt = ay_r + bx + by;
        end
        c_sh_nxt = c_sh_r >> 1; s_sh_nxt = s_sh_r >> 1;
        cnt_nxt = cnt_r + 5'd1;
      end
      P_FIN: begin
        ox_nxt = rnd_sat(rx); oy_nxt = rnd_sat(ry);
        done_nxt = 1'b1; ph_nxt = P_IDLE;
      end
      default: ph_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      ph_r <= ph_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    vx_sh_r <= vx_sh_nxt; vy_sh_r <= vy_sh_nxt;
    c_sh_r <= c_sh_nxt; s_sh_r <= s_sh_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt;
  end

  assign done = done_r;
  assign ox = ox_r;
  assign oy = oy_r;
endmodule

>>> sv/transformed_mesh_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_mesh_bounding_box
// Screen-space bounding box of a rotated, scaled and offset triangle mesh.
// ----------------------------------------------------------------------------
// Each triangle word is latched on acceptance; then each of its three vertices
// passes in turn through one bit-serial transform engine (a start step, the
// size products, the rotation products, a round/saturate step and a step to
// fold the vertex into the min/max box), and ready returns after the third
// vertex is folded in. The word marked last_triangle then leaves one box
// word in an output register; the next triangle is taken the cycle after that
// word is accepted downstream, so a stalled receiver stalls the input.
// Configuration writes go straight to the registers and must arrive while the
// block is idle.
module transformed_mesh_bounding_box (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tmbb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tmbb_pkg::CfgDataW-1:0] cfg_wdata,
  tmbb_tri_if.sink                      in_tri,
  tmbb_box_if.source                    out_box
);
  import tmbb_pkg::*;
  `include "transformed_mesh_bounding_box_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  cfg_t cfg_r, cfg_nxt;
  tri_t tri_r;
  logic [1:0] st_r, st_nxt;
  logic [1:0] vtx_r, vtx_nxt;
  coord_t mnx_r, mny_r, mxx_r, mxy_r, mnx_nxt, mny_nxt, mxx_nxt, mxy_nxt;
  logic started_r, started_nxt;
  box_t box_r, box_nxt;
  logic ov_r, ov_nxt;
  logic xf_start, xf_done;
  vert_t vx, vy;
  coord_t ox, oy;
  logic signed [CoordW:0] wd, ht;
  logic acc_in;

  // Hold config; ignore unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_POS_X: cfg_nxt.pos_x = cfg_wdata;
        REG_POS_Y: cfg_nxt.pos_y = cfg_wdata;
        REG_SIZE_X: cfg_nxt.size_x = cfg_wdata[SizeW-1:0];
        REG_SIZE_Y: cfg_nxt.size_y = cfg_wdata[SizeW-1:0];
        REG_COS: cfg_nxt.cos_a = cfg_wdata[TrigW-1:0];
        REG_SIN: cfg_nxt.sin_a = cfg_wdata[TrigW-1:0];
        default: ;
      endcase
    end
  end

  assign in_tri.ready = (st_r == S_IDLE) && !ov_r;
  assign acc_in = in_tri.valid && in_tri.ready;

  always_comb begin
    case (vtx_r)
      2'd0: begin vx = tri_r.a_x; vy = tri_r.a_y; end
      2'd1: begin vx = tri_r.b_x; vy = tri_r.b_y; end
      default: begin vx = tri_r.c_x; vy = tri_r.c_y; end
    endcase
  end

  tmbb_xform u_xf (
    .clk(clk), .rst_n(rst_n), .start(xf_start), .cfg(cfg_r),
    .vx(vx), .vy(vy), .done(xf_done), .ox(ox), .oy(oy)
  );

  always_comb begin
    st_nxt = st_r; vtx_nxt = vtx_r; xf_start = 1'b0;
    mnx_nxt = mnx_r; mny_nxt = mny_r; mxx_nxt = mxx_r; mxy_nxt = mxy_r;
    started_nxt = started_r; box_nxt = box_r;
    ov_nxt = ov_r && !out_box.ready;
    wd = '0; ht = '0;
    case (st_r)
      S_IDLE: if (acc_in) begin
        st_nxt = S_RUN; vtx_nxt = 2'd0;
      end
      S_RUN: begin
        xf_start = 1'b1; st_nxt = S_WAIT;
      end
      S_WAIT: if (xf_done) begin
        // Fold the vertex in; first one seeds the box
        if (!started_r) begin
          mnx_nxt = ox; mxx_nxt = ox; mny_nxt = oy; mxy_nxt = oy;
          started_nxt = 1'b1;
        end else begin
          if (ox < mnx_r) mnx_nxt = ox;
          if (ox > mxx_r) mxx_nxt = ox;
          if (oy < mny_r) mny_nxt = oy;
          if (oy > mxy_r) mxy_nxt = oy;
        end
        if (vtx_r == 2'd2) begin
          st_nxt = S_IDLE;
          if (tri_r.last_triangle) begin
            wd = (CoordW+1)'(mxx_nxt) - (CoordW+1)'(mnx_nxt);
            ht = (CoordW+1)'(mxy_nxt) - (CoordW+1)'(mny_nxt);
            box_nxt.box_left = mnx_nxt;
            box_nxt.box_top = mny_nxt;
            box_nxt.box_width = (wd > (CoordW+1)'(8388607)) ? 23'h7FFFFF : wd[SizeW-1:0];
            box_nxt.box_height = (ht > (CoordW+1)'(8388607)) ? 23'h7FFFFF : ht[SizeW-1:0];
            ov_nxt = 1'b1;
            mnx_nxt = '0; mny_nxt = '0; mxx_nxt = '0; mxy_nxt = '0;
            started_nxt = 1'b0;
          end
        end else begin
          vtx_nxt = vtx_r + 2'd1; st_nxt = S_RUN;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vtx_r <= '0; ov_r <= 1'b0; started_r <= 1'b0;
      mnx_r <= '0; mny_r <= '0; mxx_r <= '0; mxy_r <= '0;
      cfg_r <= '{pos_x: '0, pos_y: '0, size_x: 23'd256, size_y: 23'd256,
                 cos_a: 16'sd16384, sin_a: '0};
    end else begin
      st_r <= st_nxt; vtx_r <= vtx_nxt; ov_r <= ov_nxt; started_r <= started_nxt;
      mnx_r <= mnx_nxt; mny_r <= mny_nxt; mxx_r <= mxx_nxt; mxy_r <= mxy_nxt;
      cfg_r <= cfg_nxt;
    end
    if (acc_in) tri_r <= in_tri.data;
    box_r <= box_nxt;
  end

  assign out_box.valid = ov_r;
  assign out_box.data = box_r;

  `TMBB_ASSERT_IMP(a_box_order, started_r && st_r == S_IDLE, mnx_r <= mxx_r && mny_r <= mxy_r, "box min above max")
  `TMBB_ASSERT_NXT(a_start_wait, xf_start, st_r == S_WAIT, "engine start lost")
  `TMBB_ASSERT_IMP(a_no_take_busy, acc_in, !ov_r && st_r == S_IDLE, "word taken while busy")
endmodule
